// ===== sv/csv_field_parser_top_macros.svh =====
// Assertion macros used by the field parser emitter (csvfp_back).
// Users must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef CSV_FIELD_PARSER_TOP_MACROS_SVH
`define CSV_FIELD_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CSVFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CSVFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/csvfp_pkg.sv =====
// Package for the CSV field parser: config register codes, reset values,
// the result item type and the white-space test. No dependencies.
package csvfp_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TRIM_ENABLE  = 2'd0,
        CFG_FIELD_DELIM  = 2'd1,
        CFG_RECORD_DELIM = 2'd2,
        CFG_QUOTE_CHAR   = 2'd3
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic       TRIM_RESET         = 1'b1;
    localparam logic [7:0] FIELD_DELIM_RESET  = 8'd44;
    localparam logic [7:0] RECORD_DELIM_RESET = 8'd10;
    localparam logic [7:0] QUOTE_CHAR_RESET   = 8'd34;

    // White-space characters cut by trimming
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       field_last;
        logic       record_end;
        logic       truncated;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

// ===== sv/csvfp_queue.sv =====
// Two-entry descriptor queue between the parser front and the emitter.
// Depends on nothing but its DATA_W parameter.
module csvfp_queue #(
    parameter int DATA_W = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid,
    output logic              o_full
);

    logic [DATA_W-1:0] r_slot [2];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              r_wptr;
    logic              r_rptr;

    // Occupancy after this cycle's push and pop
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Hold queued descriptors
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rptr];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

// ===== sv/csvfp_front.sv =====
// Parser front: config registers, quote tracking, field store writes and
// trim bounds; pushes one descriptor per finished field. Uses csvfp_pkg.
module csvfp_front #(
    parameter int FIELD_DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_wr_en,
    input  csvfp_pkg::t_cfg_idx                       i_cfg_addr,
    input  logic [7:0]                                i_cfg_wr_data,
    input  logic                                      i_push,
    input  logic [7:0]                                i_in_byte,
    input  logic                                      i_q_full,
    output logic                                      o_desc_push,
    output logic [2*$clog2(FIELD_DEPTH+1)+3:0]        o_desc,
    output logic                                      o_mem_we,
    output logic [$clog2(FIELD_DEPTH):0]              o_mem_addr,
    output logic [7:0]                                o_mem_data
);
    import csvfp_pkg::*;

    localparam int LenW  = $clog2(FIELD_DEPTH + 1);
    localparam int AddrW = $clog2(FIELD_DEPTH);

    typedef struct packed {
        logic            bank;
        logic [LenW-1:0] start;
        logic [LenW-1:0] stop;
        logic            rec;
        logic            ovf;
        logic            empty;
    } t_desc;

    logic       r_trim;
    logic [7:0] r_fdelim;
    logic [7:0] r_rdelim;
    logic [7:0] r_quote;

    logic             r_bank,  n_bank;
    logic [LenW-1:0]  r_len,   n_len;
    logic             r_iq,    n_iq;
    logic             r_cq,    n_cq;
    logic [LenW-1:0]  r_qs,    n_qs;
    logic             r_qsv,   n_qsv;
    logic [LenW-1:0]  r_qe,    n_qe;
    logic             r_qev,   n_qev;
    logic [AddrW-1:0] r_first, n_first;
    logic [AddrW-1:0] r_last,  n_last;
    logic             r_ts,    n_ts;
    logic             r_ovf,   n_ovf;

    logic  accept;
    t_desc desc;

    assign accept = i_push && !i_q_full;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim   <= TRIM_RESET;
            r_fdelim <= FIELD_DELIM_RESET;
            r_rdelim <= RECORD_DELIM_RESET;
            r_quote  <= QUOTE_CHAR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_TRIM_ENABLE:  r_trim   <= i_cfg_wr_data[0];
                CFG_FIELD_DELIM:  r_fdelim <= i_cfg_wr_data;
                CFG_RECORD_DELIM: r_rdelim <= i_cfg_wr_data;
                CFG_QUOTE_CHAR:   r_quote  <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Classify the accepted byte and update the field state
    always_comb begin
        logic            outside;
        logic            put;
        logic            emit;
        logic [LenW-1:0] s;
        logic [LenW-1:0] e;

        n_bank  = r_bank;
        n_len   = r_len;
        n_iq    = r_iq;
        n_cq    = r_cq;
        n_qs    = r_qs;
        n_qsv   = r_qsv;
        n_qe    = r_qe;
        n_qev   = r_qev;
        n_first = r_first;
        n_last  = r_last;
        n_ts    = r_ts;
        n_ovf   = r_ovf;
        outside = 1'b0;
        put     = 1'b0;
        emit    = 1'b0;
        s       = '0;
        e       = r_len;

        o_mem_we   = 1'b0;
        o_mem_addr = {r_bank, r_len[AddrW-1:0]};
        o_mem_data = i_in_byte;

        if (accept) begin
            // Quote handling: doubled quote is literal, anything else closes
            if (r_cq) begin
                n_cq = 1'b0;
                if (i_in_byte == r_quote) begin
                    put = 1'b1;
                end else begin
                    n_qe    = r_len;
                    n_qev   = 1'b1;
                    n_iq    = 1'b0;
                    outside = 1'b1;
                end
            end else if (r_iq) begin
                if (i_in_byte == r_quote) begin
                    n_cq = 1'b1;
                end else begin
                    put = 1'b1;
                end
            end else begin
                outside = 1'b1;
            end

            // Outside quotes: delimiters win over the quote character
            if (outside) begin
                if (i_in_byte == r_fdelim || i_in_byte == r_rdelim) begin
                    emit = 1'b1;
                end else if (i_in_byte == r_quote) begin
                    n_qs  = r_len;
                    n_qsv = 1'b1;
                    n_iq  = 1'b1;
                end else begin
                    put = 1'b1;
                end
            end
        end

        // Store the byte, or drop it when the buffer is full
        if (put) begin
            if (r_len < LenW'(FIELD_DEPTH)) begin
                o_mem_we = 1'b1;
                if (!is_space(i_in_byte)) begin
                    if (!r_ts) begin
                        n_first = r_len[AddrW-1:0];
                        n_ts    = 1'b1;
                    end
                    n_last = r_len[AddrW-1:0];
                end
                n_len = r_len + LenW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        // Trim bounds; the last quoted section is kept whole
        if (r_trim && r_ts) begin
            e = (n_qev && (n_qe > LenW'(r_last))) ? n_qe : (LenW'(r_last) + LenW'(1));
            s = (r_qsv && (r_qs < LenW'(r_first))) ? r_qs : LenW'(r_first);
        end
        if (e > r_len) begin
            e = r_len;
        end
        if (s > e) begin
            s = e;
        end

        desc.bank  = r_bank;
        desc.start = s;
        desc.stop  = e;
        desc.rec   = (i_in_byte == r_rdelim);
        desc.ovf   = r_ovf;
        desc.empty = (s == e);

        // Field end: hand the bank to the emitter and clear the field
        if (emit) begin
            n_bank  = ~r_bank;
            n_len   = '0;
            n_iq    = 1'b0;
            n_cq    = 1'b0;
            n_qs    = '0;
            n_qsv   = 1'b0;
            n_qe    = '0;
            n_qev   = 1'b0;
            n_first = '0;
            n_last  = '0;
            n_ts    = 1'b0;
            n_ovf   = 1'b0;
        end

        o_desc_push = emit;
        o_desc      = desc;
    end

    // Hold field state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_len   <= '0;
            r_iq    <= 1'b0;
            r_cq    <= 1'b0;
            r_qs    <= '0;
            r_qsv   <= 1'b0;
            r_qe    <= '0;
            r_qev   <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
            r_ts    <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_bank  <= n_bank;
            r_len   <= n_len;
            r_iq    <= n_iq;
            r_cq    <= n_cq;
            r_qs    <= n_qs;
            r_qsv   <= n_qsv;
            r_qe    <= n_qe;
            r_qev   <= n_qev;
            r_first <= n_first;
            r_last  <= n_last;
            r_ts    <= n_ts;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== sv/csvfp_back.sv =====
// Emitter: two-bank field store, walk of each queued field through the
// read port, and a two-entry result queue. Uses csvfp_pkg and the macros.
`include "csv_field_parser_top_macros.svh"

module csvfp_back #(
    parameter int FIELD_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_mem_we,
    input  logic [$clog2(FIELD_DEPTH):0]       i_mem_addr,
    input  logic [7:0]                         i_mem_data,
    input  logic                               i_desc_valid,
    input  logic [2*$clog2(FIELD_DEPTH+1)+3:0] i_desc,
    output logic                               o_desc_pop,
    input  logic                               i_pop,
    output logic                               o_empty,
    output csvfp_pkg::t_result                 o_result
);
    import csvfp_pkg::*;

    localparam int LenW       = $clog2(FIELD_DEPTH + 1);
    localparam int AddrW      = $clog2(FIELD_DEPTH);
    localparam int StoreDepth = 2 * (2 ** AddrW);

    typedef struct packed {
        logic            bank;
        logic [LenW-1:0] start;
        logic [LenW-1:0] stop;
        logic            rec;
        logic            ovf;
        logic            empty;
    } t_desc;

    t_desc head;
    assign head = i_desc;

    logic [7:0] r_store [StoreDepth];

    logic            r_active, n_active;
    logic [LenW-1:0] r_idx,    n_idx;
    logic            issue;
    logic            space;
    logic [2:0]      occ;
    t_result         meta;

    logic       r_rd_valid;
    t_result    r_rd_meta;
    logic [7:0] r_rdata;

    t_result    r_fifo [2];
    logic [1:0] r_fcnt;
    logic       r_fw;
    logic       r_fr;
    logic       pop_fire;
    t_result    fifo_in;

    assign pop_fire = i_pop && (r_fcnt != 2'd0);

    // Issue a read only if the result queue has room for it on arrival
    assign occ   = {1'b0, r_fcnt} + {2'b00, r_rd_valid} - {2'b00, pop_fire};
    assign space = (occ < 3'd2);
    assign issue = r_active && i_desc_valid && space;

    // Walk the field one byte per issue
    always_comb begin
        n_active        = r_active;
        n_idx           = r_idx;
        o_desc_pop      = 1'b0;
        meta.out_byte   = 8'd0;
        meta.has_byte   = !head.empty;
        meta.field_last = head.empty || ((r_idx + LenW'(1)) == head.stop);
        meta.record_end = head.rec;
        meta.truncated  = head.ovf;
        if (!r_active && i_desc_valid) begin
            n_active = 1'b1;
            n_idx    = head.start;
        end else if (issue) begin
            n_idx = r_idx + LenW'(1);
            if (meta.field_last) begin
                n_active   = 1'b0;
                o_desc_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_idx      <= n_idx;
            r_rd_valid <= issue;
        end
    end

    // Field store: one write port from the front, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_mem_we) begin
            r_store[i_mem_addr] <= i_mem_data;
        end
        if (issue && !head.empty) begin
            r_rdata <= r_store[{head.bank, r_idx[AddrW-1:0]}];
        end
        if (issue) begin
            r_rd_meta <= meta;
        end
    end

    // Result queue
    always_comb begin
        fifo_in          = r_rd_meta;
        fifo_in.out_byte = r_rd_meta.has_byte ? r_rdata : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= 2'd0;
            r_fw   <= 1'b0;
            r_fr   <= 1'b0;
        end else begin
            r_fcnt <= r_fcnt + {1'b0, r_rd_valid} - {1'b0, pop_fire};
            if (r_rd_valid) begin
                r_fw <= ~r_fw;
            end
            if (pop_fire) begin
                r_fr <= ~r_fr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_fifo[r_fw] <= fifo_in;
        end
    end

    assign o_empty  = (r_fcnt == 2'd0);
    assign o_result = r_fifo[r_fr];

    `CSVFP_ASSERT_NOW(a_fifo_room, r_rd_valid && !pop_fire, r_fcnt != 2'd2, "result queue overflow")
    `CSVFP_ASSERT_NOW(a_idx_in_field, issue && !head.empty, r_idx < head.stop, "read past field end")
    `CSVFP_ASSERT_NEXT(a_pop_idle, o_desc_pop, !r_active, "walker busy after field done")

endmodule

// ===== sv/csv_field_parser_top.sv =====
// Top level of the CSV field parser: front, descriptor queue and emitter; uses csvfp_pkg.
// Throughput: one byte taken per cycle while a store bank is free; the emitter gives one item
// per cycle while the result queue has room, loading each field's descriptor first.
// full stays high while both store banks hold fields not yet drained.
// Reset (synchronous, active low) empties all queues and restores config defaults.
module csv_field_parser_top #(
    parameter int FIELD_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  csvfp_pkg::t_cfg_idx i_cfg_addr,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_in_byte,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          o_out_byte,
    output logic                o_has_byte,
    output logic                o_field_last,
    output logic                o_record_end,
    output logic                o_truncated
);
    import csvfp_pkg::*;

    localparam int LenW  = $clog2(FIELD_DEPTH + 1);
    localparam int AddrW = $clog2(FIELD_DEPTH);
    localparam int DescW = 2 * LenW + 4;

    logic             desc_push;
    logic [DescW-1:0] desc_in;
    logic [DescW-1:0] desc_out;
    logic             desc_valid;
    logic             desc_pop;
    logic             q_full;
    logic             mem_we;
    logic [AddrW:0]   mem_addr;
    logic [7:0]       mem_data;
    t_result          result;

    csvfp_front #(.FIELD_DEPTH(FIELD_DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_push       (push),
        .i_in_byte    (i_in_byte),
        .i_q_full     (q_full),
        .o_desc_push  (desc_push),
        .o_desc       (desc_in),
        .o_mem_we     (mem_we),
        .o_mem_addr   (mem_addr),
        .o_mem_data   (mem_data)
    );

    csvfp_queue #(.DATA_W(DescW)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (desc_push),
        .i_data (desc_in),
        .i_pop  (desc_pop),
        .o_data (desc_out),
        .o_valid(desc_valid),
        .o_full (q_full)
    );

    csvfp_back #(.FIELD_DEPTH(FIELD_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mem_we    (mem_we),
        .i_mem_addr  (mem_addr),
        .i_mem_data  (mem_data),
        .i_desc_valid(desc_valid),
        .i_desc      (desc_out),
        .o_desc_pop  (desc_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign full         = q_full;
    assign o_out_byte   = result.out_byte;
    assign o_has_byte   = result.has_byte;
    assign o_field_last = result.field_last;
    assign o_record_end = result.record_end;
    assign o_truncated  = result.truncated;

endmodule
